// ----- sv/flrs_pkg.sv -----
package flrs_pkg;

  localparam int STORE_BYTES_DEF = 4096;
  localparam int MAX_VALUE_BYTES_DEF = 8;
  localparam int FIFO_DEPTH_DEF = 2;

  // wide enough for a region offset plus one slot at the largest store
  localparam int PTR_W = 17;

  localparam logic [1:0] CMD_SET = 2'd0;
  localparam logic [1:0] CMD_GET = 2'd1;
  localparam logic [1:0] CMD_RAW = 2'd2;
  localparam logic [1:0] CMD_CLR = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_HDR  = 2'd1;
  localparam logic [1:0] ST_NONE = 2'd2;

  localparam logic [1:0] REG_REGION = 2'd0;
  localparam logic [1:0] REG_LEN    = 2'd1;
  localparam logic [1:0] REG_END    = 2'd2;
  localparam logic [1:0] REG_ALIGN  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [63:0] new_value;
    logic [11:0] byte_address;
    logic [7:0]  byte_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [11:0] record_address;
  } out_item_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [63:0]      value;
    logic [11:0]      baddr;
    logic [7:0]       bdata;
    logic [7:0]       sum;
    logic [3:0]       len;
    logic [3:0]       slot;
    logic [PTR_W-1:0] region;
    logic [7:0]       end_b;
  } job_t;

endpackage

// ----- sv/flash_record_log_store.sv -----
// Flash record log store. Commands enter on start_i when busy_o is low and
// wait in a two-entry queue; each produces one result, shown for one cycle
// with done_o, which the receiver must take as it comes. After reset a
// clearing pass writes every store byte to 0xFF, one per cycle, with busy_o
// high. The store has one byte-wide read port and one byte-wide write port:
// a clear drops the cached record, a raw program reads then writes its byte,
// a set or get reads the header if no record is cached and scans slots, and
// a set erases a full or bad region, then writes and verifies its slot. The
// configuration port is to be written only while idle, by the user; the
// block itself does not enforce it.
module flash_record_log_store #(
  parameter int STORE_BYTES = flrs_pkg::STORE_BYTES_DEF,
  parameter int MAX_VALUE_BYTES = flrs_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  flrs_pkg::in_item_t  cmd_i,
  output logic                done_o,
  output flrs_pkg::out_item_t result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [12:0] region_q;
  logic [3:0]  len_q;
  logic [7:0]  end_q;
  logic        align_q;
  logic        wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      region_q <= 13'd4096;
      len_q    <= 4'd4;
      end_q    <= 8'd0;
      align_q  <= 1'b0;
    end else if (wr) begin
      unique case (paddr[3:2])
        flrs_pkg::REG_REGION: region_q <= pwdata[12:0];
        flrs_pkg::REG_LEN:    len_q    <= pwdata[3:0];
        flrs_pkg::REG_END:    end_q    <= pwdata[7:0];
        default:              align_q  <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      flrs_pkg::REG_REGION: prdata = {19'd0, region_q};
      flrs_pkg::REG_LEN:    prdata = {28'd0, len_q};
      flrs_pkg::REG_END:    prdata = {24'd0, end_q};
      default:              prdata = {31'd0, align_q};
    endcase
  end

  logic push, pop, fvalid, ffull, clearing;
  flrs_pkg::job_t job_in, job_out;

  assign busy_o = ffull || clearing;

  flrs_front #(
    .STORE_BYTES(STORE_BYTES),
    .MAX_VALUE_BYTES(MAX_VALUE_BYTES)
  ) u_front (
    .start_i(start_i),
    .busy_i(busy_o),
    .item_i(cmd_i),
    .region_size_i(region_q),
    .value_length_i(len_q),
    .end_byte_i(end_q),
    .align_four_i(align_q),
    .push_o(push),
    .job_o(job_in)
  );

  flrs_fifo #(
    .DEPTH(flrs_pkg::FIFO_DEPTH_DEF)
  ) u_fifo (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .data_i(job_in),
    .pop_i(pop),
    .valid_o(fvalid),
    .full_o(ffull),
    .data_o(job_out)
  );

  flrs_back #(
    .STORE_BYTES(STORE_BYTES)
  ) u_back (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .valid_i(fvalid),
    .job_i(job_out),
    .pop_o(pop),
    .clearing_o(clearing),
    .done_o(done_o),
    .result_o(result_o)
  );

endmodule

// ----- sv/flrs_front.sv -----
module flrs_front #(
  parameter int STORE_BYTES = flrs_pkg::STORE_BYTES_DEF,
  parameter int MAX_VALUE_BYTES = flrs_pkg::MAX_VALUE_BYTES_DEF
) (
  input  logic                 start_i,
  input  logic                 busy_i,
  input  flrs_pkg::in_item_t   item_i,
  input  logic [12:0]          region_size_i,
  input  logic [3:0]           value_length_i,
  input  logic [7:0]           end_byte_i,
  input  logic                 align_four_i,
  output logic                 push_o,
  output flrs_pkg::job_t       job_o
);

  localparam logic [flrs_pkg::PTR_W-1:0] StoreB = flrs_pkg::PTR_W'(STORE_BYTES);
  localparam logic [3:0] MaxL = 4'(MAX_VALUE_BYTES);

  logic [flrs_pkg::PTR_W-1:0] rs;
  logic [3:0] l;
  logic [3:0] s2;
  logic [7:0] sum;

  always_comb begin
    rs = flrs_pkg::PTR_W'(region_size_i);
    if (rs < flrs_pkg::PTR_W'(16)) rs = flrs_pkg::PTR_W'(16);
    if (rs > StoreB) rs = StoreB;
    l = value_length_i;
    if (l < 4'd1) l = 4'd1;
    if (l > MaxL) l = MaxL;
    s2 = l + 4'd2;
    if (align_four_i) s2 = (s2 + 4'd3) & 4'b1100;
    sum = 8'd0;
    for (int k = 0; k < 8; k++) begin
      if (4'(k) < l) sum = sum + item_i.new_value[k*8 +: 8];
    end
  end

  assign push_o = start_i && !busy_i;

  always_comb begin
    job_o.cmd    = item_i.command;
    job_o.value  = item_i.new_value;
    job_o.baddr  = item_i.byte_address;
    job_o.bdata  = item_i.byte_data;
    job_o.sum    = sum;
    job_o.len    = l;
    job_o.slot   = s2;
    job_o.region = rs;
    job_o.end_b  = end_byte_i;
  end

endmodule

// ----- sv/flrs_fifo.sv -----
module flrs_fifo #(
  parameter int DEPTH = flrs_pkg::FIFO_DEPTH_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  flrs_pkg::job_t data_i,
  input  logic           pop_i,
  output logic           valid_o,
  output logic           full_o,
  output flrs_pkg::job_t data_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  flrs_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0] wp_q, rp_q;
  logic [PW:0]   cnt_q;

  assign valid_o = cnt_q != '0;
  assign full_o  = cnt_q == (PW+1)'(DEPTH);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= (wp_q == PW'(DEPTH-1)) ? '0 : wp_q + PW'(1);
      if (pop_i)  rp_q <= (rp_q == PW'(DEPTH-1)) ? '0 : rp_q + PW'(1);
      if (push_i && !pop_i) cnt_q <= cnt_q + (PW+1)'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - (PW+1)'(1);
    end
  end

endmodule

// ----- sv/flrs_back.sv -----
module flrs_back #(
  parameter int STORE_BYTES = flrs_pkg::STORE_BYTES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  flrs_pkg::job_t      job_i,
  output logic                pop_o,
  output logic                clearing_o,
  output logic                done_o,
  output flrs_pkg::out_item_t result_o
);

  localparam int PW = flrs_pkg::PTR_W;
  localparam int AW = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam logic [PW-1:0] Last = PW'(STORE_BYTES - 1);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_DISP = 5'd2;
  localparam logic [4:0] S_HRD  = 5'd3;
  localparam logic [4:0] S_HCK  = 5'd4;
  localparam logic [4:0] S_SRD  = 5'd5;
  localparam logic [4:0] S_SCK  = 5'd6;
  localparam logic [4:0] S_ERS  = 5'd7;
  localparam logic [4:0] S_HWR  = 5'd8;
  localparam logic [4:0] S_WRD  = 5'd9;
  localparam logic [4:0] S_WWR  = 5'd10;
  localparam logic [4:0] S_VRD  = 5'd11;
  localparam logic [4:0] S_VCK  = 5'd12;
  localparam logic [4:0] S_GRD  = 5'd13;
  localparam logic [4:0] S_GCK  = 5'd14;
  localparam logic [4:0] S_PRD  = 5'd15;
  localparam logic [4:0] S_PWR  = 5'd16;

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rdata_q;
  logic rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0] wr_data;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  logic [4:0] state_q, state_d;
  logic [PW-1:0] a_q, a_d, i_q, i_d, cache_q, cache_d;
  flrs_pkg::job_t job_q, job_d;
  logic [7:0] sum_q, sum_d;
  logic sok_q, sok_d, fail_q, fail_d, done_q, done_d;
  logic [63:0] val_q, val_d;
  flrs_pkg::out_item_t res_q, res_d;

  logic [PW-1:0] s_w, l_w, a_end, a_next;
  logic [3:0] bi;
  logic [7:0] wbyte, hbyte;
  logic chk;

  assign s_w    = PW'(job_q.slot);
  assign l_w    = PW'(job_q.len);
  assign a_end  = a_q + s_w;
  assign a_next = a_end + s_w;
  assign bi     = i_q[3:0];

  always_comb begin
    if (bi < job_q.len) wbyte = job_q.value[bi[2:0]*8 +: 8];
    else if (bi == job_q.len) wbyte = job_q.sum;
    else wbyte = job_q.end_b;
    unique case (i_q[1:0])
      2'd0: hbyte = job_q.region[15:8];
      2'd1: hbyte = job_q.region[7:0];
      2'd2: hbyte = {4'd0, job_q.len};
      default: hbyte = job_q.end_b;
    endcase
    chk = (i_q <= l_w) || (i_q == s_w - PW'(1));
  end

  assign pop_o      = (state_q == S_IDLE) && valid_i;
  assign clearing_o = state_q == S_CLR;
  assign done_o     = done_q;
  assign result_o   = res_q;

  always_comb begin
    state_d = state_q;
    a_d = a_q;
    i_d = i_q;
    cache_d = cache_q;
    job_d = job_q;
    sum_d = sum_q;
    sok_d = sok_q;
    fail_d = fail_q;
    val_d = val_q;
    res_d = res_q;
    done_d = 1'b0;
    rd_en = 1'b0;
    wr_en = 1'b0;
    rd_addr = '0;
    wr_addr = '0;
    wr_data = 8'hFF;

    unique case (state_q)
      S_CLR: begin
        wr_en = 1'b1;
        wr_addr = i_q[AW-1:0];
        if (i_q == Last) begin
          i_d = '0;
          state_d = S_IDLE;
        end else begin
          i_d = i_q + PW'(1);
        end
      end
      S_IDLE: begin
        if (valid_i) begin
          job_d = job_i;
          state_d = S_DISP;
        end
      end
      S_DISP: begin
        res_d = '0;
        i_d = '0;
        fail_d = 1'b0;
        sum_d = '0;
        sok_d = 1'b0;
        val_d = '0;
        unique case (job_q.cmd)
          flrs_pkg::CMD_CLR: begin
            cache_d = '0;
            done_d = 1'b1;
            state_d = S_IDLE;
          end
          flrs_pkg::CMD_RAW: begin
            if (PW'(job_q.baddr) <= Last) begin
              state_d = S_PRD;
            end else begin
              done_d = 1'b1;
              state_d = S_IDLE;
            end
          end
          flrs_pkg::CMD_SET: begin
            if (cache_q == '0) begin
              state_d = S_HRD;
            end else begin
              a_d = cache_q + s_w;
              state_d = (cache_q + s_w + s_w <= job_q.region) ? S_WRD : S_ERS;
            end
          end
          default: begin
            if (cache_q == '0) begin
              state_d = S_HRD;
            end else begin
              a_d = cache_q;
              state_d = S_GRD;
            end
          end
        endcase
      end
      S_HRD: begin
        rd_en = 1'b1;
        rd_addr = i_q[AW-1:0];
        state_d = S_HCK;
      end
      S_HCK: begin
        if (rdata_q != hbyte) fail_d = 1'b1;
        if (i_q == PW'(3)) begin
          i_d = '0;
          if (fail_q || rdata_q != hbyte) begin
            if (job_q.cmd == flrs_pkg::CMD_SET) begin
              state_d = S_ERS;
            end else begin
              res_d.status = flrs_pkg::ST_HDR;
              done_d = 1'b1;
              state_d = S_IDLE;
            end
          end else begin
            a_d = PW'(4);
            state_d = S_SRD;
          end
          fail_d = 1'b0;
        end else begin
          i_d = i_q + PW'(1);
          state_d = S_HRD;
        end
      end
      S_SRD: begin
        if (a_end > job_q.region) begin
          if (job_q.cmd == flrs_pkg::CMD_SET) begin
            i_d = '0;
            state_d = S_ERS;
          end else begin
            a_d = a_q - s_w;
            state_d = S_GRD;
          end
        end else begin
          rd_en = 1'b1;
          rd_addr = AW'(a_end - PW'(1));
          state_d = S_SCK;
        end
      end
      S_SCK: begin
        if (rdata_q == 8'hFF) begin
          if (job_q.cmd == flrs_pkg::CMD_SET) begin
            state_d = S_WRD;
          end else if (a_q >= PW'(4) + s_w) begin
            a_d = a_q - s_w;
            state_d = S_GRD;
          end else begin
            res_d.status = flrs_pkg::ST_NONE;
            done_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          a_d = a_end;
          state_d = S_SRD;
        end
      end
      S_ERS: begin
        wr_en = 1'b1;
        wr_addr = i_q[AW-1:0];
        if (i_q == job_q.region - PW'(1)) begin
          i_d = '0;
          state_d = S_HWR;
        end else begin
          i_d = i_q + PW'(1);
        end
      end
      S_HWR: begin
        wr_en = 1'b1;
        wr_addr = i_q[AW-1:0];
        wr_data = hbyte;
        if (i_q == PW'(3)) begin
          i_d = '0;
          a_d = PW'(4);
          state_d = S_WRD;
        end else begin
          i_d = i_q + PW'(1);
        end
      end
      S_WRD: begin
        rd_en = 1'b1;
        rd_addr = AW'(a_q + i_q);
        state_d = S_WWR;
      end
      S_WWR: begin
        wr_en = 1'b1;
        wr_addr = AW'(a_q + i_q);
        wr_data = rdata_q & wbyte;
        if (i_q == s_w - PW'(1)) begin
          i_d = '0;
          fail_d = 1'b0;
          state_d = S_VRD;
        end else begin
          i_d = i_q + PW'(1);
          state_d = S_WRD;
        end
      end
      S_VRD: begin
        rd_en = 1'b1;
        rd_addr = AW'(a_q + i_q);
        state_d = S_VCK;
      end
      S_VCK: begin
        if (chk && rdata_q != wbyte) fail_d = 1'b1;
        if (i_q == s_w - PW'(1)) begin
          i_d = '0;
          if (fail_q || (chk && rdata_q != wbyte)) begin
            a_d = a_end;
            state_d = (a_next > job_q.region) ? S_ERS : S_WRD;
          end else begin
            cache_d = a_q;
            res_d.record_address = a_q[11:0];
            done_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          i_d = i_q + PW'(1);
          state_d = S_VRD;
        end
      end
      S_GRD: begin
        rd_en = 1'b1;
        rd_addr = AW'(a_q + i_q);
        state_d = S_GCK;
      end
      S_GCK: begin
        if (i_q < l_w) begin
          sum_d = sum_q + rdata_q;
          val_d[bi[2:0]*8 +: 8] = rdata_q;
        end else if (i_q == l_w) begin
          sok_d = sum_q == rdata_q;
        end
        if (i_q == s_w - PW'(1)) begin
          i_d = '0;
          sum_d = '0;
          sok_d = 1'b0;
          if (sok_q && rdata_q == job_q.end_b) begin
            cache_d = a_q;
            res_d.record_address = a_q[11:0];
            res_d.read_value = val_q;
            done_d = 1'b1;
            state_d = S_IDLE;
          end else if (a_q >= PW'(4) + s_w) begin
            a_d = a_q - s_w;
            val_d = '0;
            state_d = S_GRD;
          end else begin
            res_d.status = flrs_pkg::ST_NONE;
            done_d = 1'b1;
            state_d = S_IDLE;
          end
        end else begin
          i_d = i_q + PW'(1);
          state_d = S_GRD;
        end
      end
      S_PRD: begin
        rd_en = 1'b1;
        rd_addr = AW'(job_q.baddr);
        state_d = S_PWR;
      end
      S_PWR: begin
        wr_en = 1'b1;
        wr_addr = AW'(job_q.baddr);
        wr_data = rdata_q & job_q.bdata;
        done_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
      i_q     <= '0;
      cache_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      cache_q <= cache_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q    <= a_d;
    job_q  <= job_d;
    sum_q  <= sum_d;
    sok_q  <= sok_d;
    fail_q <= fail_d;
    val_q  <= val_d;
    res_q  <= res_d;
  end

endmodule
